FILE: rtl/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared widths, types and constants of the frustum box cull block.
// ----------------------------------------------------------------------------
package cfb_pkg;

	localparam int COORD_BITS  = 16;
	localparam int PLANE_COUNT = 6;
	localparam int FRAC_BITS   = 14;
	localparam int COEF_BITS   = 16;
	localparam int AXES        = 3;

	localparam int PROD_W    = COORD_BITS + COEF_BITS;
	localparam int D_SHIFT_W = COEF_BITS + FRAC_BITS;
	// three products plus the shifted offset, two bits of growth
	localparam int SUM_W     = (PROD_W + 2 > D_SHIFT_W + 2) ? PROD_W + 2 : D_SHIFT_W + 2;
	localparam int CFG_IDX_W = $clog2(PLANE_COUNT);
	localparam int CFG_W     = 4 * COEF_BITS;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COEF_BITS-1:0]  coef_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [SUM_W-1:0]      sum_t;
	typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
	typedef logic [CFG_W-1:0]             cfg_data_t;

	typedef struct packed {
		coef_t d;
		coef_t c;
		coef_t b;
		coef_t a;
	} plane_t;

	typedef struct packed {
		coord_t z_max;
		coord_t y_max;
		coord_t x_max;
		coord_t z_min;
		coord_t y_min;
		coord_t x_min;
	} box_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} pipe_en_t;

endpackage

FILE: rtl/cfb_if.sv
// ----------------------------------------------------------------------------
// cfb_box_if / cfb_vis_if
// Valid/ready channels for box beats in and visibility beats out.
// ----------------------------------------------------------------------------
interface cfb_box_if import cfb_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t x_min;
	coord_t y_min;
	coord_t z_min;
	coord_t x_max;
	coord_t y_max;
	coord_t z_max;

	modport source (output valid, x_min, y_min, z_min, x_max, y_max, z_max, input ready);
	modport sink (input valid, x_min, y_min, z_min, x_max, y_max, z_max, output ready);
endinterface

interface cfb_vis_if ();
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface

FILE: rtl/cfb_plane.sv
// ----------------------------------------------------------------------------
// cfb_plane
// Three-stage test of one box against one plane: products, per-axis maximum,
// sum and sign. Reject means every corner lies on or behind the plane.
// ----------------------------------------------------------------------------
module cfb_plane import cfb_pkg::*; (
	input  logic     clk,
	input  plane_t   plane,
	input  box_t     box,
	input  pipe_en_t en,
	output logic     reject_s3
);

	coef_t  coef   [AXES];
	coord_t lo     [AXES];
	coord_t hi     [AXES];
	prod_t  lo_s1  [AXES];
	prod_t  hi_s1  [AXES];
	coef_t  d_s1;
	prod_t  max_s2 [AXES];
	coef_t  d_s2;
	sum_t   sum_c;

	always_comb begin
		coef[0] = plane.a;
		coef[1] = plane.b;
		coef[2] = plane.c;
		lo[0]   = box.x_min;
		lo[1]   = box.y_min;
		lo[2]   = box.z_min;
		hi[0]   = box.x_max;
		hi[1]   = box.y_max;
		hi[2]   = box.z_max;
	end

	// the highest corner takes the larger product on each axis independently
	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int i = 0; i < AXES; i++) begin
				lo_s1[i] <= prod_t'(coef[i]) * prod_t'(lo[i]);
				hi_s1[i] <= prod_t'(coef[i]) * prod_t'(hi[i]);
			end
			d_s1 <= plane.d;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int i = 0; i < AXES; i++) begin
				max_s2[i] <= (lo_s1[i] > hi_s1[i]) ? lo_s1[i] : hi_s1[i];
			end
			d_s2 <= d_s1;
		end
	end

	assign sum_c = sum_t'(max_s2[0]) + sum_t'(max_s2[1]) + sum_t'(max_s2[2])
		+ (sum_t'(d_s2) <<< FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			reject_s3 <= sum_c[SUM_W-1] || (sum_c == '0);
		end
	end

endmodule

FILE: rtl/frustum_box_cull.sv
// ----------------------------------------------------------------------------
// frustum_box_cull
// Visibility test of an axis-aligned box against six programmable planes.
// ----------------------------------------------------------------------------
// Accepts one box per cycle while the output side is ready and returns one
// visible bit per box. Every plane has its own multipliers in three pipeline
// stages (coefficient products, per-axis corner maximum, sum and sign test),
// so throughput is one box per clock when not stalled. Stalls on the output
// fill bubbles first, so input ready only drops once all three stages hold a
// box. The user must write planes through the configuration port only while
// the pipeline is empty; the block does not enforce this. After reset all
// planes are zero and every box is culled.
module frustum_box_cull import cfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  cfg_idx_t  cfg_index,
	input  cfg_data_t cfg_data,
	cfb_box_if.sink   box,
	cfb_vis_if.source result
);

	plane_t   plane_q [PLANE_COUNT];
	logic     reject_s3 [PLANE_COUNT];
	logic     valid_s1;
	logic     valid_s2;
	logic     valid_s3;
	logic     rdy1;
	logic     rdy2;
	logic     rdy3;
	pipe_en_t en;
	box_t     box_c;
	logic     any_reject;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PLANE_COUNT; i++) begin
				plane_q[i] <= '0;
			end
		end else if (cfg_we) begin
			for (int i = 0; i < PLANE_COUNT; i++) begin
				if (cfg_index == CFG_IDX_W'(i)) begin
					plane_q[i] <= plane_t'(cfg_data);
				end
			end
		end
	end

	// a stage advances when it is empty or the next one advances
	assign rdy3 = !valid_s3 || result.ready;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign en.s1 = rdy1;
	assign en.s2 = rdy2;
	assign en.s3 = rdy3;

	assign box.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= box.valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		box_c.x_min = box.x_min;
		box_c.y_min = box.y_min;
		box_c.z_min = box.z_min;
		box_c.x_max = box.x_max;
		box_c.y_max = box.y_max;
		box_c.z_max = box.z_max;
	end

	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
		cfb_plane u_plane (
			.clk       (clk),
			.plane     (plane_q[p]),
			.box       (box_c),
			.en        (en),
			.reject_s3 (reject_s3[p])
		);
	end

	always_comb begin
		any_reject = 1'b0;
		for (int i = 0; i < PLANE_COUNT; i++) begin
			any_reject = any_reject | reject_s3[i];
		end
	end

	assign result.valid   = valid_s3;
	assign result.visible = !any_reject;

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!box.ready |-> (valid_s1 && valid_s2 && valid_s3))
		else $error("input blocked with a bubble in the pipeline");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(box.valid && box.ready) |=> valid_s1)
		else $error("accepted box did not reach stage 1");

	a_stage2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rdy3) |=> valid_s2)
		else $error("stage 2 beat lost during stall");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && !valid_s2) |=> !valid_s3)
		else $error("output beat repeated after delivery");

endmodule
